// ===== src/mfsp_pkg.sv =====
// shared types and constants for the midi file stream parser
package mfsp_pkg;

    // result kinds
    localparam logic [3:0] K_HEADER     = 4'd0;
    localparam logic [3:0] K_NOTE_OFF   = 4'd1;
    localparam logic [3:0] K_NOTE_ON    = 4'd2;
    localparam logic [3:0] K_POLY_PRESS = 4'd3;
    localparam logic [3:0] K_CONTROL    = 4'd4;
    localparam logic [3:0] K_PROGRAM    = 4'd5;
    localparam logic [3:0] K_CH_PRESS   = 4'd6;
    localparam logic [3:0] K_BEND       = 4'd7;
    localparam logic [3:0] K_SYSEX      = 4'd8;
    localparam logic [3:0] K_META       = 4'd9;
    localparam logic [3:0] K_PAYLOAD    = 4'd10;
    localparam logic [3:0] K_SYX_END    = 4'd11;
    localparam logic [3:0] K_BAD_HDR    = 4'd12;
    localparam logic [3:0] K_BAD_TRK    = 4'd13;

    // one result item, 145 bits
    typedef struct packed {
        logic [15:0] division;
        logic        last_of_event;
        logic [7:0]  payload_byte;
        logic [27:0] payload_length;
        logic [7:0]  meta_type;
        logic [13:0] bend;
        logic [6:0]  second_value;
        logic [6:0]  first_value;
        logic [3:0]  channel;
        logic [31:0] position;
        logic [15:0] track_index;
        logic [3:0]  kind;
    } t_result;

endpackage

// ===== src/mfsp_queue.sv =====
// small result queue between parser and output
module mfsp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mfsp_pkg::t_result i_data,
    output logic             o_almost_full,
    output logic             o_valid,
    input  logic             i_ready,
    output mfsp_pkg::t_result o_data
);
    import mfsp_pkg::*;

    t_result    r_mem [4];
    logic [1:0] r_wp;
    logic [1:0] r_rp;
    logic [2:0] r_cnt;
    logic       w_pop;

    assign o_valid       = (r_cnt != 3'd0);
    assign w_pop         = o_valid && i_ready;
    assign o_data        = r_mem[r_rp];
    // room held back for the beat in flight
    assign o_almost_full = (r_cnt >= 3'd3);

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (i_push) r_wp <= r_wp + 2'd1;
            if (w_pop)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'd0, i_push} - {2'd0, w_pop};
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) !(i_push && r_cnt == 3'd4))
        else $error("queue overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 3'd4)
        else $error("queue count out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready && !i_push) |=> (r_cnt == $past(r_cnt)))
        else $error("queue lost an entry while stalled");
endmodule

// ===== src/mfsp_parser.sv =====
// byte classifier and parse state machine
module mfsp_parser #(
    parameter int POSITION_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    output logic              o_push,
    output mfsp_pkg::t_result o_res
);
    import mfsp_pkg::*;

    // PH_TRK_REDO: a stand-in data byte retaken as the first chunk header byte
    localparam logic [3:0] PH_HDR = 4'd0, PH_TRK = 4'd1, PH_DELTA = 4'd2, PH_STATUS = 4'd3,
        PH_DATA1 = 4'd4, PH_DATA2 = 4'd5, PH_SYX_LEN = 4'd6, PH_SYX_DATA = 4'd7,
        PH_META_TYPE = 4'd8, PH_META_LEN = 4'd9, PH_META_DATA = 4'd10, PH_IDLE = 4'd11,
        PH_TRK_REDO = 4'd15;
    localparam int PW = POSITION_WIDTH;

    logic [3:0]  r_ph, n_ph;
    logic [3:0]  r_bc, n_bc;
    logic [15:0] r_tx, n_tx;
    logic [15:0] r_tn, n_tn;
    logic [31:0] r_clen, n_clen;
    logic [31:0] r_used, n_used;
    logic [PW-1:0] r_tick, n_tick;
    logic [7:0]  r_rs, n_rs;
    logic [27:0] r_acc, n_acc;
    logic [7:0]  r_hs, n_hs;
    logic [7:0]  r_hd, n_hd;
    logic [27:0] r_left, n_left;
    logic        n_emit;
    t_result     n_res;

    // header and track magic bytes
    function automatic logic [7:0] f_magic(input logic [1:0] idx, input logic trk);
        case (idx)
            2'd0:    f_magic = 8'h4D;
            2'd1:    f_magic = 8'h54;
            2'd2:    f_magic = trk ? 8'h72 : 8'h68;
            default: f_magic = trk ? 8'h6B : 8'h64;
        endcase
    endfunction

    // next state; a data byte at status time is handled in the same cycle
    always_comb begin
        logic [31:0] used;
        logic [7:0]  s;
        logic [3:0]  ph;
        logic [27:0] acc;
        logic        done;
        logic        tend;
        logic [15:0] tn1;
        logic [27:0] left1;
        logic [13:0] bsum;
        n_ph = r_ph; n_bc = r_bc; n_tx = r_tx; n_tn = r_tn; n_clen = r_clen;
        n_tick = r_tick; n_rs = r_rs; n_acc = r_acc; n_hs = r_hs; n_hd = r_hd;
        n_left = r_left; n_emit = 1'b0; n_res = '0;
        used = r_used; s = 8'd0; ph = r_ph; done = 1'b0; tend = 1'b0;
        acc = {r_acc[20:0], i_byte[6:0]};
        left1 = r_left - 28'd1;
        tn1 = r_tn + 16'd1;
        bsum = {i_byte[6:0], r_hd[6:0]} - 14'd8192;
        n_res.track_index = r_tn;
        n_res.position = 32'(r_tick);
        if (ph == PH_STATUS) begin
            if (i_byte[7]) begin
                s = i_byte; n_rs = i_byte; used = used + 32'd1;
            end else begin
                s = r_rs;
            end
            if (s[7:4] >= 4'h8 && s[7:4] <= 4'hE) begin
                n_hs = s;
                ph = i_byte[7] ? PH_IDLE : PH_DATA1;
                n_ph = PH_DATA1;
            end else if (s == 8'hF0) begin
                n_acc = '0; acc = {21'd0, i_byte[6:0]};
                ph = i_byte[7] ? PH_IDLE : PH_SYX_LEN; n_ph = PH_SYX_LEN;
            end else if (s == 8'hFF) begin
                ph = i_byte[7] ? PH_IDLE : PH_META_TYPE; n_ph = PH_META_TYPE;
            end else begin
                done = 1'b1;
                // a stand-in data byte is reparsed as delta or chunk header
                ph = i_byte[7] ? PH_IDLE : ((used >= r_clen) ? PH_TRK_REDO : PH_DELTA);
                acc = {21'd0, i_byte[6:0]};
            end
            if (ph != PH_IDLE && ph != PH_TRK_REDO) used = used + 32'd1;
        end else if (r_ph >= PH_DELTA && r_ph <= PH_META_DATA) begin
            used = used + 32'd1;
        end
        case (ph)
            PH_HDR: begin
                if (r_bc < 4'd4 && i_byte != f_magic(r_bc[1:0], 1'b0)) begin
                    n_emit = 1'b1; n_res.kind = K_BAD_HDR; n_ph = PH_IDLE;
                end else if (r_bc == 4'd13) begin
                    n_emit = 1'b1; n_res.kind = K_HEADER; n_res.track_index = r_tx;
                    n_res.division = {r_hd, i_byte}; n_tn = '0;
                    n_ph = (r_tx == 16'd0) ? PH_IDLE : PH_TRK; n_bc = '0;
                end else begin
                    if (r_bc == 4'd10 || r_bc == 4'd11) n_tx = {r_tx[7:0], i_byte};
                    if (r_bc == 4'd12) n_hd = i_byte;
                    n_bc = r_bc + 4'd1;
                end
            end
            PH_TRK: begin
                if (r_bc < 4'd4 && i_byte != f_magic(r_bc[1:0], 1'b1)) begin
                    n_emit = 1'b1; n_res.kind = K_BAD_TRK; n_ph = PH_IDLE;
                end else begin
                    if (r_bc >= 4'd4) n_clen = {r_clen[23:0], i_byte};
                    if (r_bc == 4'd7) begin
                        used = '0; n_tick = '0; n_rs = '0;
                        if ({r_clen[23:0], i_byte} == 32'd0) tend = 1'b1;
                        else begin n_acc = '0; n_ph = PH_DELTA; end
                    end else n_bc = r_bc + 4'd1;
                end
            end
            PH_TRK_REDO: begin
                // reparse as chunk header byte after track end
                if (tn1 == r_tx) begin
                    n_tn = tn1; n_ph = PH_IDLE;
                end else begin
                    n_tn = tn1; n_bc = 4'd1;
                    if (i_byte != f_magic(2'd0, 1'b1)) begin
                        n_emit = 1'b1; n_res.kind = K_BAD_TRK;
                        n_res.track_index = tn1; n_res.position = 32'(r_tick);
                        n_ph = PH_IDLE;
                    end else n_ph = PH_TRK;
                end
                done = 1'b0;
            end
            PH_DELTA: begin
                n_acc = acc;
                if (!i_byte[7]) begin
                    n_tick = r_tick + PW'(acc); n_ph = PH_STATUS;
                end else n_ph = PH_DELTA;
                done = 1'b0;
            end
            PH_DATA1: begin
                n_hd = {1'b0, i_byte[6:0]};
                if (n_hs[7:4] == 4'hC || n_hs[7:4] == 4'hD) begin
                    n_emit = 1'b1;
                    n_res.kind = (n_hs[7:4] == 4'hC) ? K_PROGRAM : K_CH_PRESS;
                    n_res.channel = n_hs[3:0]; n_res.first_value = i_byte[6:0];
                    done = 1'b1;
                end else n_ph = PH_DATA2;
            end
            PH_DATA2: begin
                n_emit = 1'b1;
                n_res.kind = K_NOTE_OFF + {1'b0, r_hs[6:4]};
                n_res.channel = r_hs[3:0]; n_res.first_value = r_hd[6:0];
                n_res.second_value = i_byte[6:0];
                if (r_hs[7:4] == 4'hE) n_res.bend = bsum;
                done = 1'b1;
            end
            PH_SYX_LEN, PH_META_LEN: begin
                n_acc = acc;
                if (!i_byte[7]) begin
                    n_left = acc; n_emit = 1'b1;
                    n_res.kind = (ph == PH_SYX_LEN) ? K_SYSEX : K_META;
                    if (ph == PH_META_LEN) n_res.meta_type = r_hd;
                    n_res.payload_length = acc;
                    n_res.last_of_event = (acc == 28'd0);
                    if (acc == 28'd0) done = 1'b1;
                    else n_ph = (ph == PH_SYX_LEN) ? PH_SYX_DATA : PH_META_DATA;
                end
            end
            PH_SYX_DATA: begin
                n_emit = 1'b1; n_res.payload_byte = i_byte;
                if (i_byte[7]) begin
                    n_res.kind = K_SYX_END; n_res.last_of_event = 1'b1; done = 1'b1;
                end else begin
                    n_left = left1; n_res.kind = K_PAYLOAD;
                    n_res.last_of_event = (left1 == 28'd0); done = (left1 == 28'd0);
                end
            end
            PH_META_TYPE: begin
                n_hd = i_byte; n_acc = '0; n_ph = PH_META_LEN;
            end
            PH_META_DATA: begin
                n_left = left1; n_emit = 1'b1; n_res.kind = K_PAYLOAD;
                n_res.meta_type = r_hd; n_res.payload_byte = i_byte;
                n_res.last_of_event = (left1 == 28'd0); done = (left1 == 28'd0);
            end
            default: begin
                if (r_ph == PH_STATUS) begin
                    if (done) begin
                        if (used >= r_clen) tend = 1'b1;
                        else begin n_acc = '0; n_ph = PH_DELTA; end
                        done = 1'b0;
                    end
                end else n_ph = PH_IDLE;
            end
        endcase
        if (done) begin
            if (used >= r_clen) tend = 1'b1;
            else begin n_acc = '0; n_ph = PH_DELTA; end
        end
        if (tend) begin
            n_tn = tn1;
            if (tn1 == r_tx) n_ph = PH_IDLE;
            else begin n_ph = PH_TRK; n_bc = '0; end
        end
        n_used = used;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= PH_HDR; r_bc <= '0; r_tx <= '0; r_tn <= '0; r_clen <= '0;
            r_used <= '0; r_tick <= '0; r_rs <= '0; r_acc <= '0; r_hs <= '0;
            r_hd <= '0; r_left <= '0; o_push <= 1'b0;
        end else begin
            o_push <= i_valid && n_emit;
            if (i_valid) begin
                r_ph <= n_ph; r_bc <= n_bc; r_tx <= n_tx; r_tn <= n_tn;
                r_clen <= n_clen; r_used <= n_used; r_tick <= n_tick; r_rs <= n_rs;
                r_acc <= n_acc; r_hs <= n_hs; r_hd <= n_hd; r_left <= n_left;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        o_res <= n_res;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ph == PH_IDLE) |=> (r_ph == PH_IDLE))
        else $error("left idle phase without reset");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_ph <= PH_IDLE)
        else $error("phase code out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ph == PH_IDLE) |=> !o_push)
        else $error("result while idle");
endmodule

// ===== src/midi_file_stream_parser_top.sv =====
// top level of the midi file stream parser
// Takes one file byte per beat on the slave stream and gives at most one result beat per
// byte on the master stream. The result kind travels on tuser and the last beat of a sysex
// or meta event is flagged on tlast. A byte is taken every cycle while the four-entry result
// queue holds fewer than three beats; a data byte standing in for a running status is
// handled in the same cycle. Results pass through the parser's result register and the queue.
// The parse state machine sets the one-cycle rate; output stalls reach the input only once
// three queue entries are taken, one entry being held back for the beat in flight.
module midi_file_stream_parser_top #(
    parameter int POSITION_WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // file_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [143:0] m_axis_tdata,   // track_index, position, channel, first_value,
                                         // second_value, bend, meta_type, payload_length,
                                         // payload_byte, division, zero pad
    output logic [3:0]   m_axis_tuser,   // kind
    output logic         m_axis_tlast    // last_of_event
);
    import mfsp_pkg::*;

    logic    w_push;
    logic    w_afull;
    t_result w_res;
    t_result w_out;

    assign s_axis_tready = !w_afull;

    mfsp_parser #(.POSITION_WIDTH(POSITION_WIDTH)) u_parser (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid && s_axis_tready), .i_byte(s_axis_tdata),
        .o_push(w_push), .o_res(w_res)
    );

    mfsp_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_data(w_res),
        .o_almost_full(w_afull), .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_data(w_out)
    );

    // output beat packing
    assign m_axis_tdata = {4'd0, w_out.division, w_out.payload_byte, w_out.payload_length,
                           w_out.meta_type, w_out.bend, w_out.second_value,
                           w_out.first_value, w_out.channel, w_out.position,
                           w_out.track_index};
    assign m_axis_tuser = w_out.kind;
    assign m_axis_tlast = w_out.last_of_event;
endmodule
